>>> hw/rtl/olist_pkg.sv
// Shared types, codes and sizes of the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none

package olist_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 10;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 3;
  localparam int STAT_W   = 3;
  localparam int LEN_W    = 9;
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  typedef logic [CMD_W-1:0]  cmd_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [DATA_W-1:0] data_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [POS_W-1:0]  pos_t;
  typedef logic [LEN_W-1:0]  len_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  localparam cmd_t CMD_INSERT = cmd_t'(0);
  localparam cmd_t CMD_DELETE = cmd_t'(1);
  localparam cmd_t CMD_GET    = cmd_t'(2);
  localparam cmd_t CMD_LOCATE = cmd_t'(3);
  localparam cmd_t CMD_CLEAR  = cmd_t'(4);
  localparam cmd_t CMD_INIT   = cmd_t'(5);

  localparam stat_t ST_OK       = stat_t'(0);
  localparam stat_t ST_BAD_POS  = stat_t'(1);
  localparam stat_t ST_FULL     = stat_t'(2);
  localparam stat_t ST_EMPTY    = stat_t'(3);
  localparam stat_t ST_PRESENT  = stat_t'(4);
  localparam stat_t ST_BAD_INIT = stat_t'(5);

  typedef struct packed {
    logic load;
    logic step;
    logic fin;
  } olist_ctl_t;

  typedef struct packed {
    logic rem_zero;
    logic out_free;
  } olist_sts_t;

endpackage

`default_nettype wire

>>> hw/rtl/olist_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module olist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/olist_ctrl.sv
// Command sequencer of the ordered list engine.
`timescale 1ns / 1ps
`default_nettype none

module olist_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire olist_pkg::olist_sts_t sts,
  output      olist_pkg::olist_ctl_t ctl
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SWEEP = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (sts.rem_zero) begin
          state_nxt = S_DRAIN;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          ctl.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

`default_nettype wire

>>> hw/rtl/olist_dp.sv
// Datapath of the ordered list engine: entry RAM, count, sweep pointers, result register.
`timescale 1ns / 1ps
`default_nettype none

module olist_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [olist_pkg::CMD_W-1:0] in_command,
  input  wire logic [olist_pkg::POS_W-1:0] in_position,
  input  wire logic signed [olist_pkg::DATA_W-1:0] in_element_value,
  input  wire logic [olist_pkg::POS_W-1:0] in_init_length,
  input  wire olist_pkg::olist_ctl_t       ctl,
  output      olist_pkg::olist_sts_t       sts,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [olist_pkg::STAT_W-1:0] out_status,
  output      logic signed [olist_pkg::DATA_W-1:0] out_read_value,
  output      logic [olist_pkg::LEN_W-1:0] out_list_length,
  output      logic                        out_is_empty
);

  olist_pkg::cnt_t  count_r, count_nxt;
  olist_pkg::cmd_t  cmd_r;
  olist_pkg::data_t val_r;
  olist_pkg::cnt_t  ilen_r;
  olist_pkg::stat_t st_r;
  olist_pkg::addr_t pos0_r;
  olist_pkg::addr_t ptr_r;
  olist_pkg::cnt_t  rem_r;
  logic             dv_r;
  olist_pkg::addr_t da_r;
  olist_pkg::data_t rdv_r;
  logic             hit_r;

  logic             out_valid_r;
  olist_pkg::stat_t out_status_r;
  olist_pkg::data_t out_read_value_r;
  olist_pkg::len_t  out_list_length_r;
  logic             out_is_empty_r;

  olist_pkg::cmp_t  pos_w, cnt_w, ilen_w, span_w;
  olist_pkg::pos_t  pos_m1;
  olist_pkg::stat_t ld_st;
  olist_pkg::addr_t ld_ptr;
  olist_pkg::cnt_t  ld_rem;
  logic             ok;
  olist_pkg::stat_t fin_st;

  logic             ram_we, ram_re;
  olist_pkg::addr_t ram_waddr;
  olist_pkg::data_t ram_wdata, ram_rdata;

  olist_ram #(
    .WIDTH(olist_pkg::DATA_W),
    .DEPTH(olist_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Checks and sweep setup for a new command
  always_comb begin
    pos_w  = olist_pkg::cmp_t'(in_position);
    cnt_w  = olist_pkg::cmp_t'(count_r);
    ilen_w = olist_pkg::cmp_t'(in_init_length);
    span_w = cnt_w - pos_w + olist_pkg::cmp_t'(1);
    pos_m1 = in_position - olist_pkg::pos_t'(1);
    ld_st  = olist_pkg::ST_OK;
    ld_ptr = olist_pkg::addr_t'(pos_m1);
    ld_rem = '0;
    case (in_command)
      olist_pkg::CMD_INSERT: begin
        if (in_position == '0 || pos_w > cnt_w + olist_pkg::cmp_t'(1)) begin
          ld_st = olist_pkg::ST_BAD_POS;
        end else if (count_r == olist_pkg::cnt_t'(olist_pkg::CAPACITY)) begin
          ld_st = olist_pkg::ST_FULL;
        end else begin
          ld_rem = olist_pkg::cnt_t'(span_w);
          ld_ptr = olist_pkg::addr_t'(count_r - olist_pkg::cnt_t'(1));
        end
      end
      olist_pkg::CMD_DELETE: begin
        if (in_position == '0 || pos_w > cnt_w) begin
          ld_st = olist_pkg::ST_BAD_POS;
        end else begin
          ld_rem = olist_pkg::cnt_t'(span_w);
        end
      end
      olist_pkg::CMD_GET: begin
        if (in_position == '0 || pos_w > cnt_w) begin
          ld_st = olist_pkg::ST_BAD_POS;
        end else begin
          ld_rem = olist_pkg::cnt_t'(1);
        end
      end
      olist_pkg::CMD_LOCATE: begin
        if (count_r == '0) begin
          ld_st = olist_pkg::ST_EMPTY;
        end else begin
          ld_rem = count_r;
          ld_ptr = '0;
        end
      end
      olist_pkg::CMD_INIT: begin
        if (ilen_w > olist_pkg::cmp_t'(olist_pkg::CAPACITY)) begin
          ld_st = olist_pkg::ST_BAD_INIT;
        end else begin
          ld_rem = olist_pkg::cnt_t'(in_init_length);
          ld_ptr = '0;
        end
      end
      default: begin
        ld_st = olist_pkg::ST_OK;
      end
    endcase
  end

  assign ok = (st_r == olist_pkg::ST_OK);

  // RAM write port: init fill, shift writes, insert value
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = da_r;
    ram_wdata = ram_rdata;
    ram_re    = ctl.step && (cmd_r != olist_pkg::CMD_INIT);
    if (ctl.step && cmd_r == olist_pkg::CMD_INIT) begin
      ram_we    = 1'b1;
      ram_waddr = ptr_r;
      ram_wdata = '0;
    end else if (dv_r) begin
      if (cmd_r == olist_pkg::CMD_INSERT) begin
        ram_we    = 1'b1;
        ram_waddr = da_r + olist_pkg::addr_t'(1);
      end else if (cmd_r == olist_pkg::CMD_DELETE && da_r != pos0_r) begin
        ram_we    = 1'b1;
        ram_waddr = da_r - olist_pkg::addr_t'(1);
      end
    end else if (ctl.fin && ok && cmd_r == olist_pkg::CMD_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = pos0_r;
      ram_wdata = val_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ok) begin
      case (cmd_r)
        olist_pkg::CMD_INSERT: count_nxt = count_r + olist_pkg::cnt_t'(1);
        olist_pkg::CMD_DELETE: count_nxt = count_r - olist_pkg::cnt_t'(1);
        olist_pkg::CMD_CLEAR:  count_nxt = '0;
        olist_pkg::CMD_INIT:   count_nxt = ilen_r;
        default:               count_nxt = count_r;
      endcase
    end
    fin_st = st_r;
    if (ok && cmd_r == olist_pkg::CMD_LOCATE && hit_r) begin
      fin_st = olist_pkg::ST_PRESENT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rem_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      dv_r <= ram_re;
      if (ctl.load) begin
        rem_r <= ld_rem;
      end else if (ctl.step) begin
        rem_r <= rem_r - olist_pkg::cnt_t'(1);
      end
      if (ctl.fin) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r  <= in_command;
      val_r  <= in_element_value;
      ilen_r <= olist_pkg::cnt_t'(in_init_length);
      st_r   <= ld_st;
      pos0_r <= olist_pkg::addr_t'(pos_m1);
      ptr_r  <= ld_ptr;
      rdv_r  <= '0;
      hit_r  <= 1'b0;
    end else begin
      if (ctl.step) begin
        if (cmd_r == olist_pkg::CMD_INSERT) begin
          ptr_r <= ptr_r - olist_pkg::addr_t'(1);
        end else begin
          ptr_r <= ptr_r + olist_pkg::addr_t'(1);
        end
      end
      if (dv_r) begin
        if (cmd_r == olist_pkg::CMD_GET ||
            (cmd_r == olist_pkg::CMD_DELETE && da_r == pos0_r)) begin
          rdv_r <= ram_rdata;
        end
        if (cmd_r == olist_pkg::CMD_LOCATE && ram_rdata == val_r) begin
          hit_r <= 1'b1;
        end
      end
    end
    da_r <= ptr_r;
    if (ctl.fin) begin
      out_status_r      <= fin_st;
      out_read_value_r  <= rdv_r;
      out_list_length_r <= olist_pkg::len_t'(count_nxt);
      out_is_empty_r    <= (count_nxt == '0);
    end
  end

  assign sts.rem_zero = (rem_r == '0);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_list_length = out_list_length_r;
  assign out_is_empty    = out_is_empty_r;

endmodule

`default_nettype wire

>>> hw/rtl/ordered_array_list_engine.sv
// Top level of the ordered list engine: sequencer plus datapath.
//
//  channel  direction  ports                                           transfer when
//  in       input      command, position, element_value, init_length   in_valid & !in_stall
//  out      output     status, read_value, list_length, is_empty       out_valid & !out_stall
//
// One command at a time. Each command sweeps n entries of the list, where n is
// count - position + 1 for insert and delete, count for locate, init_length for init,
// 1 for get, 0 otherwise. Sweeps read through the single RAM read port; init writes.
// Reset (rst_n low, synchronous) empties the list; entry contents need no clearing.
// A stalled result holds the next command in its final cycle until the result transfers.
`timescale 1ns / 1ps
`default_nettype none

module ordered_array_list_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [olist_pkg::CMD_W-1:0] in_command,
  input  wire logic [olist_pkg::POS_W-1:0] in_position,
  input  wire logic signed [olist_pkg::DATA_W-1:0] in_element_value,
  input  wire logic [olist_pkg::POS_W-1:0] in_init_length,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [olist_pkg::STAT_W-1:0] out_status,
  output      logic signed [olist_pkg::DATA_W-1:0] out_read_value,
  output      logic [olist_pkg::LEN_W-1:0] out_list_length,
  output      logic                        out_is_empty
);

  olist_pkg::olist_ctl_t ctl;
  olist_pkg::olist_sts_t sts;

  olist_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .ctl      (ctl)
  );

  olist_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_command       (in_command),
    .in_position      (in_position),
    .in_element_value (in_element_value),
    .in_init_length   (in_init_length),
    .ctl              (ctl),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_read_value   (out_read_value),
    .out_list_length  (out_list_length),
    .out_is_empty     (out_is_empty)
  );

endmodule

`default_nettype wire

>>> hw/rtl/olist_chk.sv
// Port-level checks of the ordered list engine and their bind.
`timescale 1ns / 1ps
`default_nettype none

module olist_chk (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [olist_pkg::STAT_W-1:0] out_status,
  input wire logic signed [olist_pkg::DATA_W-1:0] out_read_value,
  input wire logic [olist_pkg::LEN_W-1:0] out_list_length,
  input wire logic                        out_is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
      $stable(out_read_value) && $stable(out_list_length))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second command taken while one is in progress");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_list_length == '0)))
    else $error("empty flag disagrees with length");

  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != olist_pkg::ST_OK |-> out_read_value == '0)
    else $error("read value on a failed or non-read command");

endmodule

bind ordered_array_list_engine olist_chk u_olist_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_status      (out_status),
  .out_read_value  (out_read_value),
  .out_list_length (out_list_length),
  .out_is_empty    (out_is_empty)
);

`default_nettype wire
